>>> sv/pelc_pkg.sv
// ----------------------------------------------------------------------------
// pelc_pkg: shared constants and helpers of the light-curve binner
// Table sizes, field widths, command and register codes, sequencer states.
// ----------------------------------------------------------------------------
package pelc_pkg;

  localparam int MAX_WINDOWS        = 128;
  localparam int MAX_INTERVALS      = 64;
  localparam int MAX_BINS_PER_EVENT = 64;

  localparam int TIME_W   = 40;
  localparam int WAVE_W   = 21;
  localparam int WEIGHT_W = 24;
  localparam int SUM_W    = 48;
  localparam int RATE_W   = 48;
  localparam int INV_W    = 32;
  localparam int BYTE_W   = 8;

  localparam int WCNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int ICNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int WADDR_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int IADDR_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int IDX_W   = (WCNT_W > ICNT_W) ? WCNT_W : ICNT_W;
  localparam int CLOSE_W = $clog2(MAX_BINS_PER_EVENT + 1);

  // configuration port
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_BIN_WIDTH = 3'd0;
  localparam logic [2:0] REG_INV_WIDTH = 3'd1;
  localparam logic [2:0] REG_GRATING   = 3'd2;
  localparam logic [2:0] REG_APERTURE  = 3'd3;
  localparam logic [2:0] REG_DAY_NIGHT = 3'd4;

  // request commands
  localparam logic [1:0] CMD_EVENT    = 2'd0;
  localparam logic [1:0] CMD_WINDOW   = 2'd1;
  localparam logic [1:0] CMD_INTERVAL = 2'd2;

  localparam logic [1:0] DN_DAY   = 2'd0;
  localparam logic [1:0] DN_NIGHT = 2'd1;

  localparam logic [1:0] AP_OTHER = 2'd3;
  localparam logic [7:0] CH_LIF   = 8'd3;
  localparam logic [7:0] CH_SIC   = 8'd7;
  localparam logic [7:0] DAY_MASK = 8'd254;

  localparam logic [TIME_W-1:0] BIN_WIDTH_RST = 40'd65536;
  localparam logic [INV_W-1:0]  INV_WIDTH_RST = 32'd65536;

  // sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] S_CHECK    = 4'd1;
  localparam logic [ST_W-1:0] S_ISCAN    = 4'd2;
  localparam logic [ST_W-1:0] S_RATE_HI  = 4'd3;
  localparam logic [ST_W-1:0] S_RATE_LO  = 4'd4;
  localparam logic [ST_W-1:0] S_RATE_SUM = 4'd5;
  localparam logic [ST_W-1:0] S_EMIT     = 4'd6;
  localparam logic [ST_W-1:0] S_ADV      = 4'd7;
  localparam logic [ST_W-1:0] S_DIV      = 4'd8;
  localparam logic [ST_W-1:0] S_SKIP     = 4'd9;
  localparam logic [ST_W-1:0] S_WSCAN    = 4'd10;
  localparam logic [ST_W-1:0] S_APPLY    = 4'd11;
  localparam logic [ST_W-1:0] S_FLUSH    = 4'd12;

  // day/night flag test
  function automatic logic time_ok(input logic [1:0] mode, input logic [7:0] f);
    logic ok;
    if (mode == DN_DAY) begin
      ok = (f == 8'd1);
    end else if (mode == DN_NIGHT) begin
      ok = (f == 8'd0);
    end else begin
      ok = ((f & DAY_MASK) == 8'd0);
    end
    return ok;
  endfunction

  // channel test against grating and aperture
  function automatic logic channel_ok(input logic gs, input logic [1:0] ap,
                                      input logic [7:0] ch);
    logic [7:0] want;
    want = (gs ? CH_SIC : CH_LIF) - {6'd0, ap};
    return (ap != AP_OTHER) && (ch == want);
  endfunction

endpackage

>>> sv/pelc_if.sv
// ----------------------------------------------------------------------------
// pelc_in_if / pelc_out_if: request and result channels
// Valid/ready channels carrying the event or table-load request and the bin.
// ----------------------------------------------------------------------------
interface pelc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [39:0] event_time;
  logic [20:0] wavelength;
  logic [23:0] weight;
  logic [7:0]  channel;
  logic [7:0]  time_flags;
  logic [7:0]  location_flags;
  logic [39:0] range_start;
  logic [39:0] range_stop;

  modport source (output valid, cmd, event_time, wavelength, weight, channel,
                  time_flags, location_flags, range_start, range_stop,
                  input ready);
  modport sink (input valid, cmd, event_time, wavelength, weight, channel,
                time_flags, location_flags, range_start, range_stop,
                output ready);
endinterface

interface pelc_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] bin_time;
  logic [47:0] bin_rate;
  logic        gap_skipped;
  logic        last_of_run;

  modport source (output valid, bin_time, bin_rate, gap_skipped, last_of_run,
                  input ready);
  modport sink (input valid, bin_time, bin_rate, gap_skipped, last_of_run,
                output ready);
endinterface

>>> sv/pelc_ram.sv
// ----------------------------------------------------------------------------
// pelc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pelc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pelc_rem.sv
// ----------------------------------------------------------------------------
// pelc_rem: iterative remainder unit
// Restoring division, one quotient bit a cycle, gives dividend mod divisor.
// ----------------------------------------------------------------------------
module pelc_rem
  import pelc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [TIME_W-1:0] remainder
);

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W:0]   rem;
  logic [TIME_W-1:0] num;
  logic [TIME_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TIME_W:0]   trial;

  assign trial     = {rem[TIME_W-1:0], num[TIME_W-1]};
  assign remainder = rem[TIME_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and conditional subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
      den <= divisor;
    end else if (busy) begin
      num <= {num[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
      end else begin
        rem <= trial;
      end
    end
  end

endmodule

>>> sv/photon_event_light_curve_binner_unit.sv
// ----------------------------------------------------------------------------
// photon_event_light_curve_binner_unit: photon event light-curve binner
// Sequencer over table RAMs, a shared 32x32 multiplier and a remainder unit.
// ----------------------------------------------------------------------------
// Table loads are taken in the idle state. A photon event holds off new requests
// until done: for each bin it closes, the sequencer checks the bin, walks the
// good-time interval RAM, then passes the sum through the shared multiplier
// (high half, low half, sum) and hands the result on when the bin is good,
// and last moves the bin on; a bin already marked bad skips the walk. Past
// the 64-bin limit the remainder unit jumps to the bin holding the event;
// last come the window RAM walk, the flag test and the flush of the result.
// An event that closes no bin goes straight to the window RAM walk.
// Results wait in a holding register and an output register, so a stall on
// the result side only halts the sequencer while both are full and a result
// must move on.
module photon_event_light_curve_binner_unit
  import pelc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  pelc_in_if.sink            ev_in,
  pelc_out_if.source         bin_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // configuration registers
  logic [TIME_W-1:0] bin_width;
  logic [INV_W-1:0]  inv_width;
  logic              grating_select;
  logic [1:0]        aperture_mode;
  logic [1:0]        day_night_mode;
  logic [2:0]        reg_idx;
  logic              cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width      <= BIN_WIDTH_RST;
      inv_width      <= INV_WIDTH_RST;
      grating_select <= 1'b0;
      aperture_mode  <= 2'd0;
      day_night_mode <= 2'd2;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_BIN_WIDTH: bin_width      <= pwdata[TIME_W-1:0];
        REG_INV_WIDTH: inv_width      <= pwdata[INV_W-1:0];
        REG_GRATING:   grating_select <= pwdata[0];
        REG_APERTURE:  aperture_mode  <= pwdata[1:0];
        REG_DAY_NIGHT: day_night_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_BIN_WIDTH: prdata = {{(PDATA_W-TIME_W){1'b0}}, bin_width};
      REG_INV_WIDTH: prdata = {{(PDATA_W-INV_W){1'b0}}, inv_width};
      REG_GRATING:   prdata = {{(PDATA_W-1){1'b0}}, grating_select};
      REG_APERTURE:  prdata = {{(PDATA_W-2){1'b0}}, aperture_mode};
      REG_DAY_NIGHT: prdata = {{(PDATA_W-2){1'b0}}, day_night_mode};
      default:       prdata = '0;
    endcase
  end

  logic [TIME_W-1:0] w_eff;
  assign w_eff = (bin_width == '0) ? TIME_W'(1) : bin_width;

  // sequencer state and bin state
  logic [ST_W-1:0]    state;
  logic [WCNT_W-1:0]  window_count;
  logic [ICNT_W-1:0]  interval_count;
  logic [TIME_W-1:0]  bin_start;
  logic [TIME_W:0]    bin_end;
  logic [SUM_W-1:0]   bin_sum;
  logic               bin_bad;
  logic               skip_pending;
  logic [CLOSE_W-1:0] closed;
  logic [IDX_W-1:0]   idx;
  logic               rd_pend;
  logic               hit_a;
  logic               hit_b;

  // latched event
  logic [TIME_W-1:0]   ev_time;
  logic [WAVE_W-1:0]   ev_wave;
  logic [WEIGHT_W-1:0] ev_weight;
  logic [BYTE_W-1:0]   ev_chan;
  logic [BYTE_W-1:0]   ev_tflags;
  logic [BYTE_W-1:0]   ev_lflags;

  // pending result, held until it is known whether another follows
  logic              pend_valid;
  logic [TIME_W-1:0] pend_time;
  logic [RATE_W-1:0] pend_rate;
  logic              pend_gap;
  logic [RATE_W-1:0] new_rate;

  // output register
  logic              o_valid;
  logic [TIME_W-1:0] o_time;
  logic [RATE_W-1:0] o_rate;
  logic              o_gap;
  logic              o_last;
  logic              can_push;
  logic              o_push;

  assign bin_out.valid       = o_valid;
  assign bin_out.bin_time    = o_time;
  assign bin_out.bin_rate    = o_rate;
  assign bin_out.gap_skipped = o_gap;
  assign bin_out.last_of_run = o_last;
  assign can_push            = !o_valid || bin_out.ready;
  assign o_push              = pend_valid && can_push &&
                               ((state == S_EMIT) || (state == S_FLUSH));

  assign ev_in.ready = (state == S_IDLE);
  logic in_acc;
  assign in_acc = ev_in.valid && ev_in.ready;

  // table RAMs
  logic                        w_we;
  logic                        i_we;
  logic [2*WAVE_W-1:0]         w_rdata;
  logic [2*TIME_W-1:0]         i_rdata;
  logic [WAVE_W-1:0]           w_lo;
  logic [WAVE_W-1:0]           w_hi;
  logic [TIME_W-1:0]           i_lo;
  logic [TIME_W-1:0]           i_hi;

  assign w_we = in_acc && (ev_in.cmd == CMD_WINDOW) &&
                (window_count < WCNT_W'(MAX_WINDOWS));
  assign i_we = in_acc && (ev_in.cmd == CMD_INTERVAL) &&
                (interval_count < ICNT_W'(MAX_INTERVALS));

  pelc_ram #(.WIDTH(2*WAVE_W), .DEPTH(MAX_WINDOWS)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (window_count[WADDR_W-1:0]),
    .wdata ({ev_in.range_stop[WAVE_W-1:0], ev_in.range_start[WAVE_W-1:0]}),
    .raddr (idx[WADDR_W-1:0]),
    .rdata (w_rdata)
  );

  pelc_ram #(.WIDTH(2*TIME_W), .DEPTH(MAX_INTERVALS)) u_iram (
    .clk   (clk),
    .we    (i_we),
    .waddr (interval_count[IADDR_W-1:0]),
    .wdata ({ev_in.range_stop, ev_in.range_start}),
    .raddr (idx[IADDR_W-1:0]),
    .rdata (i_rdata)
  );

  assign w_lo = w_rdata[WAVE_W-1:0];
  assign w_hi = w_rdata[2*WAVE_W-1:WAVE_W];
  assign i_lo = i_rdata[TIME_W-1:0];
  assign i_hi = i_rdata[2*TIME_W-1:TIME_W];

  // scan bookkeeping
  logic scan_more;
  logic scan_done;
  always_comb begin
    if (state == S_WSCAN) begin
      scan_more = ({{(IDX_W-WCNT_W){1'b0}}, window_count} > idx);
    end else begin
      scan_more = ({{(IDX_W-ICNT_W){1'b0}}, interval_count} > idx);
    end
    scan_done = !scan_more && !rd_pend;
  end

  // shared multiplier: high half of the sum, then the low 16 bits
  logic [31:0]          mul_a;
  logic [63:0]          mul_p;
  logic [63:0]          prod_hi;
  logic [63:0]          prod_lo;
  logic [64:0]          rate_sum;
  assign mul_a    = (state == S_RATE_HI) ? bin_sum[SUM_W-1:16] : {16'd0, bin_sum[15:0]};
  assign mul_p    = mul_a * inv_width;
  assign rate_sum = {1'b0, prod_hi} + {17'd0, prod_lo[63:16]};

  // remainder unit for the jump past the bin limit
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_rem;
  assign div_start = (state == S_CHECK) && ({1'b0, ev_time} >= bin_end) &&
                     (closed == CLOSE_W'(MAX_BINS_PER_EVENT));

  pelc_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ev_time - bin_start),
    .divisor   (w_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  logic            ev_keep;
  logic [SUM_W:0]  sum_add;
  assign ev_keep = hit_a && (ev_lflags == '0) &&
                   channel_ok(grating_select, aperture_mode, ev_chan);
  assign sum_add = {1'b0, bin_sum} + {{(SUM_W-WEIGHT_W+1){1'b0}}, ev_weight};

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window_count   <= '0;
      interval_count <= '0;
      bin_start      <= '0;
      bin_end        <= {1'b0, BIN_WIDTH_RST};
      bin_sum        <= '0;
      bin_bad        <= 1'b0;
      skip_pending   <= 1'b0;
      closed         <= '0;
      idx            <= '0;
      rd_pend        <= 1'b0;
      hit_a          <= 1'b0;
      hit_b          <= 1'b0;
      pend_valid     <= 1'b0;
      o_valid        <= 1'b0;
    end else begin
      if (o_push) begin
        o_valid <= 1'b1;
      end else if (o_valid && bin_out.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (w_we) begin
              window_count <= window_count + 1'b1;
            end
            if (i_we) begin
              interval_count <= interval_count + 1'b1;
            end
            if (ev_in.cmd == CMD_EVENT) begin
              ev_time   <= ev_in.event_time;
              ev_wave   <= ev_in.wavelength;
              ev_weight <= ev_in.weight;
              ev_chan   <= ev_in.channel;
              ev_tflags <= ev_in.time_flags;
              ev_lflags <= ev_in.location_flags;
              closed    <= '0;
              state     <= S_CHECK;
            end
          end
        end
        // decide whether the open bin closes
        S_CHECK: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          hit_a   <= 1'b0;
          hit_b   <= 1'b0;
          if ({1'b0, ev_time} >= bin_end) begin
            if (closed == CLOSE_W'(MAX_BINS_PER_EVENT)) begin
              state <= S_DIV;
            end else if (bin_bad) begin
              state <= S_ADV;
            end else begin
              state <= S_ISCAN;
            end
          end else begin
            state <= S_WSCAN;
          end
        end
        // both bin edges against the good-time intervals
        S_ISCAN: begin
          rd_pend <= scan_more;
          if (scan_more) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend) begin
            if (bin_start >= i_lo && bin_start <= i_hi) begin
              hit_a <= 1'b1;
            end
            if (bin_end[TIME_W-1:0] >= i_lo && bin_end[TIME_W-1:0] <= i_hi) begin
              hit_b <= 1'b1;
            end
          end
          if (scan_done) begin
            state <= (hit_a && hit_b) ? S_RATE_HI : S_ADV;
          end
        end
        S_RATE_HI: begin
          prod_hi <= mul_p;
          state   <= S_RATE_LO;
        end
        S_RATE_LO: begin
          prod_lo <= mul_p;
          state   <= S_RATE_SUM;
        end
        S_RATE_SUM: begin
          new_rate <= (rate_sum[64:RATE_W] != '0) ? '1 : rate_sum[RATE_W-1:0];
          state    <= S_EMIT;
        end
        // earlier result goes out, the new one is held back
        S_EMIT: begin
          if (!pend_valid || can_push) begin
            if (pend_valid) begin
              o_time  <= pend_time;
              o_rate  <= pend_rate;
              o_gap   <= pend_gap;
              o_last  <= 1'b0;
            end
            pend_valid   <= 1'b1;
            pend_time    <= bin_start;
            pend_rate    <= new_rate;
            pend_gap     <= skip_pending;
            skip_pending <= 1'b0;
            state        <= S_ADV;
          end
        end
        S_ADV: begin
          bin_start <= bin_end[TIME_W-1:0];
          bin_end   <= bin_end + {1'b0, w_eff};
          bin_sum   <= '0;
          bin_bad   <= 1'b0;
          closed    <= closed + 1'b1;
          state     <= S_CHECK;
        end
        // jump to the bin holding the event
        S_DIV: begin
          if (div_done) begin
            bin_start    <= ev_time - div_rem;
            skip_pending <= 1'b1;
            state        <= S_SKIP;
          end
        end
        S_SKIP: begin
          bin_end <= {1'b0, bin_start} + {1'b0, w_eff};
          idx     <= '0;
          rd_pend <= 1'b0;
          hit_a   <= 1'b0;
          state   <= S_WSCAN;
        end
        // wavelength against the windows
        S_WSCAN: begin
          rd_pend <= scan_more;
          if (scan_more) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend && ev_wave >= w_lo && ev_wave <= w_hi) begin
            hit_a <= 1'b1;
          end
          if (scan_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!time_ok(day_night_mode, ev_tflags)) begin
            bin_bad <= 1'b1;
          end
          if (ev_keep) begin
            bin_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          end
          state <= S_FLUSH;
        end
        // last result of the event
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (can_push) begin
            o_time     <= pend_time;
            o_rate     <= pend_rate;
            o_gap      <= pend_gap;
            o_last     <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/pelc_check.sv
// ----------------------------------------------------------------------------
// pelc_check: port-level checks for the light-curve binner
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pelc_check
  import pelc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TIME_W-1:0] out_time,
  input logic [RATE_W-1:0] out_rate
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_time) && $stable(out_rate))
    else $error("stalled result changed");

  // an event request keeps the block busy
  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_EVENT |=> !in_ready)
    else $error("ready right after an event");

  // a table load leaves the block ready
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd != CMD_EVENT |=> in_ready)
    else $error("not ready after a load");

endmodule

bind photon_event_light_curve_binner_unit pelc_check u_pelc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (ev_in.valid),
  .in_ready  (ev_in.ready),
  .in_cmd    (ev_in.cmd),
  .out_valid (bin_out.valid),
  .out_ready (bin_out.ready),
  .out_time  (bin_out.bin_time),
  .out_rate  (bin_out.bin_rate)
);
